FILE: rtl/core/tcsd_pkg.sv
`default_nettype none

package tcsd_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 16;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned CFG_INDEX_W     = 1;
  localparam int unsigned COUNT_W         = 5;
  localparam int unsigned ROWS_W          = 31;

  localparam logic [19:0] TS_SCALE  = 20'd1000000;
  localparam logic [31:0] DATE_BIAS = 32'h8000_0000;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ROWS,
    PH_LEN,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [1:0] {
    CT_INT32,
    CT_DATE,
    CT_TIMESTAMP,
    CT_DOUBLE
  } col_type_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_LENGTH,
    ST_NEG_LENGTH,
    ST_EMPTY
  } status_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COLUMN_COUNT,
    CFG_COLUMN_TYPES
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       msg_start;
  } cell_in_t;

  typedef struct packed {
    logic [3:0]         column_index;
    logic               is_null;
    logic signed [63:0] cell_value;
    status_e            status;
    logic               last_of_message;
  } cell_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/typed_cell_stream_decoder.sv
// A result is registered in stage 1 and then in the output stage after the byte that completes it is taken.
// Throughput: one byte per cycle; the parser takes a byte whenever its result stage is free.
// Timestamps pass a split 32x20 constant multiply, then a 64-bit add in the output stage.
// Reset: parser idle until msg_start, pipeline empty, column_count 1, column_types 0.
`default_nettype none

module typed_cell_stream_decoder #(
  parameter int unsigned MAX_COLUMNS = tcsd_pkg::MAX_COLUMNS_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  tcsd_pkg::cell_in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output tcsd_pkg::cell_out_t                   out_data_o,
  input  wire                                   cfg_we_i,
  input  wire  [tcsd_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  wire  [tcsd_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import tcsd_pkg::*;

  localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic [COUNT_W-1:0] column_count_q;
  logic [31:0]        column_types_q;

  phase_e             phase_q, phase_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [63:0]        asm_q, asm_d;
  logic [ROWS_W-1:0]  rows_q, rows_d;
  logic [CW-1:0]      col_q, col_d;
  logic               long_q, long_d;

  phase_e             ph;
  logic [2:0]         cnt;
  logic [63:0]        asm_v;
  logic [ROWS_W-1:0]  rows;
  logic [CW-1:0]      col;
  logic               long_v;
  logic [63:0]        asm_n;
  logic [2:0]         cnt_n;
  logic [31:0]        word;

  logic [5:0]         eff_cols;
  logic [5:0]         col_inc;
  logic               col_wrap;
  logic [ROWS_W-1:0]  rows_dec;
  logic               adv_last;
  logic [4:0]         col5;
  col_type_e          ctype;
  logic [31:0]        date_v;

  logic               emit;
  cell_out_t          res;
  logic               res_mul;
  logic [51:0]        plo;
  logic [31:0]        phi;

  logic               s1_valid_q;
  cell_out_t          s1_res_q;
  logic               s1_mul_q;
  logic [51:0]        s1_plo_q;
  logic [31:0]        s1_phi_q;
  logic               out_valid_q;
  cell_out_t          out_q;
  cell_out_t          out_d;

  logic               s1_load;
  logic               s2_load;
  logic               accept;

  assign s2_load    = !out_valid_q || !out_stall_i;
  assign s1_load    = !s1_valid_q || s2_load;
  assign in_stall_o = !s1_load;
  assign accept     = in_valid_i && s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= COUNT_W'(1);
      column_types_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_COLUMN_COUNT: column_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_COLUMN_TYPES: column_types_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (column_count_q == '0) begin
      eff_cols = 6'd1;
    end else if (6'(column_count_q) > 6'(MAX_COLUMNS)) begin
      eff_cols = 6'(MAX_COLUMNS);
    end else begin
      eff_cols = 6'(column_count_q);
    end
  end

  always_comb begin
    ph     = phase_q;
    cnt    = cnt_q;
    asm_v  = asm_q;
    rows   = rows_q;
    col    = col_q;
    long_v = long_q;
    if (in_data_i.msg_start) begin
      ph     = PH_ROWS;
      cnt    = '0;
      asm_v  = '0;
      rows   = '0;
      col    = '0;
      long_v = 1'b0;
    end
    asm_n = {asm_v[55:0], in_data_i.data_byte};
    cnt_n = cnt + 3'd1;
    word  = asm_n[31:0];

    col_inc  = 6'(col) + 6'd1;
    col_wrap = (col_inc >= eff_cols);
    rows_dec = rows - ROWS_W'(1);
    adv_last = col_wrap && (rows_dec == '0);
    col5     = 5'(col);
    ctype    = col5[4] ? CT_INT32 : col_type_e'(2'(column_types_q >> {col5[3:0], 1'b0}));
    date_v   = asm_n[31:0] - DATE_BIAS;
    plo      = asm_n[31:0] * TS_SCALE;
    phi      = asm_n[63:32] * TS_SCALE;

    phase_d = ph;
    cnt_d   = cnt_n;
    asm_d   = asm_n;
    rows_d  = rows;
    col_d   = col;
    long_d  = long_v;

    emit                = 1'b0;
    res_mul             = 1'b0;
    res.column_index    = 4'(col);
    res.is_null         = 1'b0;
    res.cell_value      = '0;
    res.status          = ST_OK;
    res.last_of_message = 1'b0;

    unique case (ph)
      PH_IDLE: begin
        cnt_d = cnt;
        asm_d = asm_v;
      end
      PH_ROWS: begin
        if (cnt_n == 3'd4) begin
          cnt_d = '0;
          asm_d = '0;
          if (word == '0 || word[31]) begin
            phase_d             = PH_IDLE;
            emit                = 1'b1;
            res.column_index    = '0;
            res.status          = ST_EMPTY;
            res.last_of_message = 1'b1;
          end else begin
            rows_d  = word[ROWS_W-1:0];
            col_d   = '0;
            phase_d = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        if (cnt_n == 3'd4) begin
          emit = 1'b1;
          if (word == '0) begin
            res.is_null         = 1'b1;
            res.last_of_message = adv_last;
            col_d   = col_wrap ? '0 : col_inc[CW-1:0];
            rows_d  = col_wrap ? rows_dec : rows;
            cnt_d   = '0;
            asm_d   = '0;
            phase_d = adv_last ? PH_IDLE : PH_LEN;
          end else if (word[31]) begin
            res.status          = ST_NEG_LENGTH;
            res.last_of_message = 1'b1;
            phase_d             = PH_IDLE;
          end else if (word != ((ctype == CT_TIMESTAMP || ctype == CT_DOUBLE) ? 32'd8
                                                                              : 32'd4)) begin
            res.status          = ST_BAD_LENGTH;
            res.last_of_message = 1'b1;
            phase_d             = PH_IDLE;
          end else begin
            emit    = 1'b0;
            long_d  = (ctype == CT_TIMESTAMP || ctype == CT_DOUBLE);
            cnt_d   = '0;
            asm_d   = '0;
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (long_v ? (cnt_n == 3'd0) : (cnt_n == 3'd4)) begin
          emit                = 1'b1;
          res.last_of_message = adv_last;
          unique case (ctype)
            CT_INT32:     res.cell_value = {{32{asm_n[31]}}, asm_n[31:0]};
            CT_DATE:      res.cell_value = {{32{date_v[31]}}, date_v};
            CT_TIMESTAMP: res_mul = 1'b1;
            CT_DOUBLE:    res.cell_value = asm_n;
            default:      res.cell_value = asm_n;
          endcase
          col_d   = col_wrap ? '0 : col_inc[CW-1:0];
          rows_d  = col_wrap ? rows_dec : rows;
          cnt_d   = '0;
          asm_d   = '0;
          phase_d = adv_last ? PH_IDLE : PH_LEN;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      asm_q   <= '0;
      rows_q  <= '0;
      col_q   <= '0;
      long_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      asm_q   <= asm_d;
      rows_q  <= rows_d;
      col_q   <= col_d;
      long_q  <= long_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= accept && emit;
      end
      if (s2_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_comb begin
    out_d = s1_res_q;
    if (s1_mul_q) begin
      out_d.cell_value = {s1_phi_q, 32'b0} + {12'b0, s1_plo_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_res_q <= res;
      s1_mul_q <= res_mul;
      s1_plo_q <= plo;
      s1_phi_q <= phi;
    end
    if (s2_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: verif/typed_cell_stream_decoder_test.sv
module typed_cell_stream_decoder_test;
  import tcsd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_BYTES = 1000;
  localparam int PHASE_BYTES = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  cell_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  cell_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  typed_cell_stream_decoder DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cell_in_t msg_byte_q[$];
  cell_out_t cell_expect_q[$];
  int items_queued = 0;
  int noise_bytes = 0;
  int in_count = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  logic [COUNT_W-1:0] gen_count = 5'd1;
  logic [31:0] gen_types = '0;

  logic [COUNT_W-1:0] cfg_count = 5'd1;
  logic [31:0] cfg_types = '0;
  phase_e prs_phase = PH_IDLE;
  logic [2:0] prs_cnt = '0;
  logic [63:0] prs_acc = '0;
  logic [ROWS_W-1:0] prs_rows = '0;
  logic [4:0] prs_col = '0;
  logic [3:0] prs_len = '0;
  cell_out_t got;
  cell_out_t want;

  function automatic logic [4:0] active_columns(input logic [COUNT_W-1:0] n);
    if (n == 0) return 5'd1;
    if (n > MAX_COLUMNS_DEF) return 5'(MAX_COLUMNS_DEF);
    return n;
  endfunction

  function automatic col_type_e cell_kind();
    return prs_col[4] ? CT_INT32 : col_type_e'(cfg_types[2*prs_col[3:0] +: 2]);
  endfunction

  function automatic logic next_cell();
    logic done;
    done = 1'b0;
    prs_col = prs_col + 5'd1;
    if (prs_col >= active_columns(cfg_count)) begin
      prs_col = '0;
      prs_rows = prs_rows - 1'b1;
      done = (prs_rows == 0);
    end
    prs_cnt = '0;
    prs_acc = '0;
    prs_phase = done ? PH_IDLE : PH_LEN;
    return done;
  endfunction

  task automatic decode_byte(input cell_in_t item);
    cell_out_t res;
    logic hit;
    logic [31:0] word;
    logic [3:0] need;
    logic [63:0] val;
    hit = 1'b0;
    res = '0;
    if (item.msg_start) begin
      prs_phase = PH_ROWS;
      prs_cnt = '0;
      prs_acc = '0;
      prs_rows = '0;
      prs_col = '0;
      prs_len = '0;
    end
    if (prs_phase != PH_IDLE) begin
      prs_acc = {prs_acc[55:0], item.data_byte};
      prs_cnt = prs_cnt + 3'd1;
      word = prs_acc[31:0];
      case (prs_phase)
        PH_ROWS: if (prs_cnt == 3'd4) begin
          prs_cnt = '0;
          prs_acc = '0;
          if (word == 0 || word[31]) begin
            prs_phase = PH_IDLE;
            hit = 1'b1;
            res.status = ST_EMPTY;
            res.last_of_message = 1'b1;
          end else begin
            prs_rows = word[ROWS_W-1:0];
            prs_col = '0;
            prs_phase = PH_LEN;
          end
        end
        PH_LEN: if (prs_cnt == 3'd4) begin
          hit = 1'b1;
          res.column_index = prs_col[3:0];
          need = (cell_kind() == CT_TIMESTAMP || cell_kind() == CT_DOUBLE) ? 4'd8 : 4'd4;
          if (word == 0) begin
            res.is_null = 1'b1;
            res.last_of_message = next_cell();
          end else if (word[31]) begin
            prs_phase = PH_IDLE;
            res.status = ST_NEG_LENGTH;
            res.last_of_message = 1'b1;
          end else if (word != {28'd0, need}) begin
            prs_phase = PH_IDLE;
            res.status = ST_BAD_LENGTH;
            res.last_of_message = 1'b1;
          end else begin
            hit = 1'b0;
            prs_len = need;
            prs_cnt = '0;
            prs_acc = '0;
            prs_phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: if (((prs_cnt == 3'd0) ? 4'd8 : {1'b0, prs_cnt}) >= prs_len) begin
          case (cell_kind())
            CT_INT32: val = {{32{prs_acc[31]}}, prs_acc[31:0]};
            CT_DATE: begin
              word = prs_acc[31:0] - DATE_BIAS;
              val = {{32{word[31]}}, word};
            end
            CT_TIMESTAMP: val = prs_acc * 64'd1000000;
            default: val = prs_acc;
          endcase
          hit = 1'b1;
          res.column_index = prs_col[3:0];
          res.cell_value = val;
          res.last_of_message = next_cell();
        end
        default: prs_phase = PH_IDLE;
      endcase
    end
    if (hit) cell_expect_q = {cell_expect_q, res};
  endtask

  function automatic int sender_gap_pct();
    return (in_count < 350) ? 37 : (in_count < 700) ? 80 : 0;
  endfunction

  function automatic int receiver_gap_pct();
    return (in_count < 350) ? 80 : (in_count < 700) ? 37 : 0;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (msg_byte_q.size() != 0 && $urandom_range(99) >= sender_gap_pct()) begin
        in_valid_i <= 1'b1;
        in_data_i <= msg_byte_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
      end else if (!hold_done && in_count > 150 && msg_byte_q.size() > 40) begin
        hold_left = 120;
        hold_done = 1'b1;
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < receiver_gap_pct());
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire = (in_valid_i === 1'b1) && (in_stall_o === 1'b0);
      out_fire = (out_valid_o === 1'b1) && (out_stall_i === 1'b0);
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_COLUMN_COUNT) cfg_count = cfg_data_i[COUNT_W-1:0];
        else cfg_types = cfg_data_i;
      end
      if (in_fire) begin
        decode_byte(in_data_i);
        in_count++;
      end
      if (out_fire) begin
        got = out_data_o;
        if (cell_expect_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %p", $time, got);
          error_count++;
        end else begin
          want = cell_expect_q.pop_front();
          if (got.column_index !== want.column_index) begin
            $display("%0t column_index expected %0d actual %0d", $time,
                     want.column_index, got.column_index);
            error_count++;
          end
          if (got.is_null !== want.is_null) begin
            $display("%0t is_null expected %0b actual %0b", $time, want.is_null, got.is_null);
            error_count++;
          end
          if (got.cell_value !== want.cell_value) begin
            $display("%0t cell_value expected %h actual %h", $time,
                     want.cell_value, got.cell_value);
            error_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t status expected %0d actual %0d", $time, want.status, got.status);
            error_count++;
          end
          if (got.last_of_message !== want.last_of_message) begin
            $display("%0t last_of_message expected %0b actual %0b", $time,
                     want.last_of_message, got.last_of_message);
            error_count++;
          end
        end
      end
      if (in_fire || out_fire || cfg_we_i) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic start);
    cell_in_t item;
    item.data_byte = b;
    item.msg_start = start;
    msg_byte_q = {msg_byte_q, item};
    items_queued++;
  endtask

  task automatic queue_word(input logic [31:0] w, input logic start);
    for (int k = 3; k >= 0; k--) queue_byte(w[8*k +: 8], start && (k == 3));
  endtask

  function automatic logic [7:0] rand_payload();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_message(input logic [31:0] rows, input logic allow_break);
    longint total;
    int fault_at;
    int cut_at;
    int col;
    int width;
    col_type_e ctype;
    logic [31:0] len;
    total = rows[31] ? 0 : longint'(rows) * active_columns(gen_count);
    fault_at = -1;
    cut_at = -1;
    queue_word(rows, 1'b1);
    if (total == 0) return;
    if (total > 64) cut_at = $urandom_range(4);
    else if (allow_break && $urandom_range(3) == 0) fault_at = $urandom_range(int'(total) - 1);
    else if (allow_break && $urandom_range(3) == 0) cut_at = $urandom_range(int'(total) - 1);
    for (int pos = 0; pos < total; pos++) begin
      if (pos == cut_at) begin
        repeat ($urandom_range(6)) queue_byte(rand_payload(), 1'b0);
        return;
      end
      col = pos % active_columns(gen_count);
      ctype = col_type_e'(gen_types[2*col +: 2]);
      width = (ctype == CT_TIMESTAMP || ctype == CT_DOUBLE) ? 8 : 4;
      if (pos == fault_at) begin
        case ($urandom_range(2))
          0: len = {1'b1, 31'($urandom)};
          1: len = {1'b0, 31'($urandom)};
          default: begin
            len = $urandom_range(1, 12);
            if (len == width) len = len + 1;
          end
        endcase
        queue_word(len, 1'b0);
        return;
      end
      if ($urandom_range(9) == 0) begin
        queue_word(32'd0, 1'b0);
      end else begin
        queue_word(width, 1'b0);
        repeat (width) queue_byte(rand_payload(), 1'b0);
      end
    end
  endtask

  task automatic wait_drained();
    while (in_count != items_queued || cell_expect_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
  endtask

  initial begin
    int base;
    int phase_base;
    logic [COUNT_W-1:0] cnt;
    logic [31:0] types;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_byte(8'hA5, 1'b0);
    noise_bytes++;
    queue_word(32'd0, 1'b1);
    queue_word(32'h8000_0000, 1'b1);
    queue_word(32'd1, 1'b1);
    queue_word(32'd0, 1'b0);
    queue_word(32'd1, 1'b1);
    queue_word(32'hFFFF_FFFF, 1'b0);
    base = items_queued - noise_bytes;

    for (int p = 0; items_queued - noise_bytes - base < RANDOM_BYTES; p++) begin
      case (p)
        0: begin cnt = 5'd1; types = 32'h0000_0000; end
        1: begin cnt = 5'd16; types = 32'hFFFF_FFFF; end
        2: begin cnt = 5'd0; types = $urandom; end
        3: begin cnt = 5'd31; types = $urandom; end
        4: begin cnt = 5'd17; types = 32'hAAAA_AAAA; end
        5: begin cnt = 5'd4; types = 32'h5555_5555; end
        default: begin cnt = 5'($urandom_range(0, 31)); types = $urandom; end
      endcase
      wait_drained();
      @(negedge clk_i);
      write_reg(CFG_COLUMN_COUNT, {27'($urandom), cnt});
      write_reg(CFG_COLUMN_TYPES, types);
      cfg_we_i <= 1'b0;
      gen_count = cnt;
      gen_types = types;

      phase_base = items_queued - noise_bytes;
      while (items_queued - noise_bytes - phase_base < PHASE_BYTES) begin
        case ($urandom_range(19))
          0: queue_message(32'd0, 1'b1);
          1: queue_message({1'b1, 31'($urandom)}, 1'b1);
          2: queue_message({1'b0, 31'($urandom)} | 32'h100, 1'b1);
          default: queue_message($urandom_range(1, (active_columns(gen_count) <= 4) ? 4 : 2),
                                 1'b1);
        endcase
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            queue_byte(8'($urandom), 1'b0);
            noise_bytes++;
          end
        end
      end
      queue_message(32'd1, 1'b0);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && cell_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
